// ----- sv/pbbm_pkg.sv -----
// Shared types and constants for the per-bunch beam moments block.
package pbbm_pkg;
   localparam int NCOORD = 6;
   localparam int COORD_W = 24;
   localparam int SUM_W = 40;
   localparam int SQ_W = 64;
   localparam int RMS_W = 23;
   localparam int TURN_W = 16;
   localparam int CFG_W = 4;
   localparam int REG_BUNCH_COUNT = 0;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [SQ_W-1:0] sq_type;

   // Command from the particle path to each lane.
   typedef struct packed {
      logic add;
      logic clear;
   } lane_cmd_type;
endpackage

// ----- sv/pbbm_lane.sv -----
// One coordinate lane: per-bunch sum and sum-of-squares accumulators.
module pbbm_lane
   import pbbm_pkg::*;
#(
   parameter int MAX_BUNCHES = 8,
   parameter int BIDX_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  lane_cmd_type      cmd,
   input  logic [BIDX_W-1:0] wr_bunch,
   input  coord_type         value,
   input  logic [BIDX_W-1:0] rd_bunch,
   output sum_type           rd_sum,
   output sq_type            rd_sq
);
   sum_type sum_ff [MAX_BUNCHES];
   sq_type  sq_ff  [MAX_BUNCHES];
   // Square registered first, accumulated into the bunch's sums in the next cycle.
   logic              add_ff;
   logic [BIDX_W-1:0] bunch_ff;
   coord_type         value_ff;
   sq_type            square_ff;
   sq_type            square_in;
   logic signed [2*COORD_W-1:0] product;

   assign product = value * value;
   assign square_in = sq_type'(product);

   always_ff @(posedge clock) begin
      if (reset) begin
         add_ff <= 1'b0;
      end else begin
         add_ff <= cmd.add;
      end
      bunch_ff <= wr_bunch;
      value_ff <= value;
      square_ff <= square_in;
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < MAX_BUNCHES; b++) begin
         if (reset || cmd.clear) begin
            sum_ff[b] <= '0;
            sq_ff[b] <= '0;
         end else if (add_ff && bunch_ff == BIDX_W'(b)) begin
            sum_ff[b] <= sum_ff[b] + sum_type'(value_ff);
            sq_ff[b] <= sq_ff[b] + square_ff;
         end
      end
   end

   assign rd_sum = sum_ff[rd_bunch];
   assign rd_sq = sq_ff[rd_bunch];
endmodule

// ----- sv/pbbm_stats.sv -----
// Serial divider and square root producing mean and rms of one accumulator pair.
module pbbm_stats
   import pbbm_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sum_type               sum,
   input  sq_type                sq,
   input  logic [COUNT_BITS-1:0] count,
   output logic                  done,
   output coord_type             mean,
   output logic [RMS_W-1:0]      rms
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MSQ  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [6:0] step_ff, step_in;
   // Two restoring dividers run side by side: |sum|/count and sq/count.
   logic [SUM_W-1:0] sq1_ff, sq1_in;
   logic [COUNT_BITS:0] r1_ff, r1_in;
   logic [SQ_W-1:0] q2_ff, q2_in;
   logic [COUNT_BITS:0] r2_ff, r2_in;
   logic [COUNT_BITS-1:0] den_ff;
   logic neg_ff;
   coord_type mean_ff, mean_in;
   logic [SQ_W-1:0] rad_ff, rad_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [SQ_W-1:0] bit_ff, bit_in;
   logic [SQ_W-1:0] msq_ff, msq_in;
   logic [COUNT_BITS:0] t1, t2;
   logic [SUM_W-1:0] abs_sum;
   logic [SQ_W-1:0] trial;
   logic signed [2*COORD_W-1:0] mean_sq;

   assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   assign t1 = {r1_ff[COUNT_BITS-1:0], sq1_ff[SUM_W-1]};
   assign t2 = {r2_ff[COUNT_BITS-1:0], q2_ff[SQ_W-1]};
   assign trial = root_ff + bit_ff;
   assign mean_sq = mean_ff * mean_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      sq1_in = sq1_ff;
      r1_in = r1_ff;
      q2_in = q2_ff;
      r2_in = r2_ff;
      mean_in = mean_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      msq_in = msq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIV;
               step_in = '0;
               sq1_in = abs_sum;
               r1_in = '0;
               q2_in = sq;
               r2_in = '0;
            end
         end
         ST_DIV: begin
            if (step_ff < 7'(SUM_W)) begin
               if (t1 >= {1'b0, den_ff}) begin
                  r1_in = t1 - {1'b0, den_ff};
                  sq1_in = {sq1_ff[SUM_W-2:0], 1'b1};
               end else begin
                  r1_in = t1;
                  sq1_in = {sq1_ff[SUM_W-2:0], 1'b0};
               end
            end
            if (t2 >= {1'b0, den_ff}) begin
               r2_in = t2 - {1'b0, den_ff};
               q2_in = {q2_ff[SQ_W-2:0], 1'b1};
            end else begin
               r2_in = t2;
               q2_in = {q2_ff[SQ_W-2:0], 1'b0};
            end
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(SQ_W - 1)) begin
               state_in = ST_MSQ;
               mean_in = neg_ff ? coord_type'(-sq1_ff) : coord_type'(sq1_ff);
            end
         end
         ST_MSQ: begin
            msq_in = SQ_W'(mean_sq);
            state_in = ST_SQRT;
            step_in = '0;
         end
         ST_SQRT: begin
            if (step_ff == 7'd0) begin
               rad_in = (q2_ff > msq_ff) ? q2_ff - msq_ff : '0;
               root_in = '0;
               bit_in = SQ_W'(1) << (SQ_W - 2);
               step_in = 7'd1;
            end else begin
               if (rad_ff >= trial) begin
                  rad_in = rad_ff - trial;
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
               step_in = step_ff + 7'd1;
               if (step_ff == 7'(SQ_W / 2)) state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      sq1_ff <= sq1_in;
      r1_ff <= r1_in;
      q2_ff <= q2_in;
      r2_ff <= r2_in;
      mean_ff <= mean_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      msq_ff <= msq_in;
      if (state_ff == ST_IDLE && start) begin
         den_ff <= count;
         neg_ff <= sum[SUM_W-1];
      end
   end

   assign done = (state_ff == ST_DONE);
   assign mean = mean_ff;
   assign rms = (root_ff > SQ_W'({RMS_W{1'b1}})) ? {RMS_W{1'b1}} : root_ff[RMS_W-1:0];
endmodule

// ----- sv/per_bunch_beam_moments_top.sv -----
// Top level of the per-bunch beam moments block.
// Particles enter one per cycle while req_stall is low; six coordinate lanes
// accumulate sum and sum of squares per bunch in parallel. A transaction with
// last_particle set starts the report: for each bunch and coordinate a shared
// serial unit divides both sums by the live count and takes an integer square
// root (skipped for a bunch with no live particles); req_stall stays high for
// the whole report.
// Outputs come bunch-major, coordinate-minor, through one output register;
// afterwards the accumulators clear and the turn number advances.
module per_bunch_beam_moments_top
   import pbbm_pkg::*;
#(
   parameter int MAX_BUNCHES = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [23:0]  req_x,
   input  logic signed [23:0]  req_px,
   input  logic signed [23:0]  req_y,
   input  logic signed [23:0]  req_py,
   input  logic signed [23:0]  req_dp,
   input  logic signed [23:0]  req_ct,
   input  logic                req_lost,
   input  logic                req_last_particle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_turn,
   output logic [2:0]          rsp_bunch,
   output logic [2:0]          rsp_coord,
   output logic signed [23:0]  rsp_mean,
   output logic [22:0]         rsp_rms,
   output logic                rsp_empty_res,
   output logic                rsp_last,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [1:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   localparam int BIDX_W = (MAX_BUNCHES > 1) ? $clog2(MAX_BUNCHES) : 1;
   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [CFG_W-1:0] bunch_count_ff;
   logic [CFG_W-1:0] nb;
   logic [BIDX_W-1:0] pbunch_ff, pbunch_in, cur_b;
   logic [COUNT_BITS-1:0] live_ff [MAX_BUNCHES];
   logic [TURN_W-1:0] turn_ff;
   logic [1:0] state_ff, state_in;
   logic [1:0] wait_ff;
   logic [BIDX_W-1:0] rb_ff;
   logic [2:0] rc_ff;
   logic do_add, accept, clear_all, start;
   lane_cmd_type cmd;
   coord_type lane_val [NCOORD];
   sum_type lane_sum [NCOORD];
   sq_type lane_sq [NCOORD];
   logic stats_done;
   coord_type st_mean;
   logic [RMS_W-1:0] st_rms;
   logic empty_b, last_res;

   // Effective bunch count: zero means one, clip at MAX_BUNCHES.
   always_comb begin
      if (bunch_count_ff == '0) nb = CFG_W'(1);
      else if (bunch_count_ff > CFG_W'(MAX_BUNCHES)) nb = CFG_W'(MAX_BUNCHES);
      else nb = bunch_count_ff;
   end

   assign cur_b = ({1'b0, pbunch_ff} >= (BIDX_W+1)'(nb)) ? '0 : pbunch_ff;
   assign pbunch_in = ((BIDX_W+1)'(cur_b) + 1'b1 >= (BIDX_W+1)'(nb)) ? '0 : cur_b + 1'b1;
   assign req_stall = (state_ff != ST_RUN);
   assign accept = req_valid && !req_stall;
   assign do_add = accept && !req_lost && live_ff[cur_b] != COUNT_MAX;
   assign empty_b = (live_ff[rb_ff] == '0);
   assign last_res = ({1'b0, rb_ff} + 1'b1 == (BIDX_W+1)'(nb)) && rc_ff == 3'(NCOORD - 1);
   assign clear_all = (state_ff == ST_OUT) && !rsp_stall && last_res;
   assign cmd.add = do_add;
   assign cmd.clear = clear_all;
   assign start = (state_ff == ST_CALC) && !empty_b;

   assign lane_val[0] = req_x;
   assign lane_val[1] = req_px;
   assign lane_val[2] = req_y;
   assign lane_val[3] = req_py;
   assign lane_val[4] = req_dp;
   assign lane_val[5] = req_ct;

   for (genvar c = 0; c < NCOORD; c++) begin : g_lane
      pbbm_lane #(.MAX_BUNCHES(MAX_BUNCHES), .BIDX_W(BIDX_W)) u_lane (
         .clock(clock), .reset(reset), .cmd(cmd), .wr_bunch(cur_b),
         .value(lane_val[c]), .rd_bunch(rb_ff),
         .rd_sum(lane_sum[c]), .rd_sq(lane_sq[c])
      );
   end

   // Merge: pick the coordinate lane under report into the shared unit.
   pbbm_stats #(.COUNT_BITS(COUNT_BITS)) u_stats (
      .clock(clock), .reset(reset), .start(start),
      .sum(lane_sum[rc_ff]), .sq(lane_sq[rc_ff]), .count(live_ff[rb_ff]),
      .done(stats_done), .mean(st_mean), .rms(st_rms)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN:  if (accept && req_last_particle) state_in = ST_WAIT;
         // let the last particle's delayed accumulation land
         ST_WAIT: if (wait_ff == 2'd1) state_in = ST_CALC;
         ST_CALC: if (empty_b || stats_done) state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall) state_in = last_res ? ST_RUN : ST_CALC;
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         bunch_count_ff <= CFG_W'(1);
         pbunch_ff <= '0;
         turn_ff <= '0;
         wait_ff <= '0;
         rb_ff <= '0;
         rc_ff <= '0;
         for (int b = 0; b < MAX_BUNCHES; b++) live_ff[b] <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff <= (state_ff == ST_WAIT) ? wait_ff + 2'd1 : 2'd0;
         if (csr_psel && csr_penable && csr_pwrite
             && csr_paddr == 2'(REG_BUNCH_COUNT * 4))
            bunch_count_ff <= csr_pwdata[CFG_W-1:0];
         if (accept) pbunch_ff <= pbunch_in;
         if (do_add) live_ff[cur_b] <= live_ff[cur_b] + 1'b1;
         if (state_ff == ST_CALC && (empty_b || stats_done)) begin
            rsp_turn <= turn_ff;
            rsp_bunch <= 3'(rb_ff);
            rsp_coord <= rc_ff;
            rsp_mean <= empty_b ? '0 : st_mean;
            rsp_rms <= empty_b ? '0 : st_rms;
            rsp_empty_res <= empty_b;
            rsp_last <= last_res;
         end
         if (state_ff == ST_OUT && !rsp_stall) begin
            if (last_res) begin
               rb_ff <= '0;
               rc_ff <= '0;
               pbunch_ff <= '0;
               turn_ff <= turn_ff + 1'b1;
               for (int b = 0; b < MAX_BUNCHES; b++) live_ff[b] <= '0;
            end else if (rc_ff == 3'(NCOORD - 1)) begin
               rc_ff <= '0;
               rb_ff <= rb_ff + 1'b1;
            end else begin
               rc_ff <= rc_ff + 3'd1;
            end
         end
      end
   end

   assign rsp_valid = (state_ff == ST_OUT);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'(REG_BUNCH_COUNT * 4))
                       ? 32'(bunch_count_ff) : 32'd0;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_RUN |-> !accept) else $error("accept while reporting");
   a_last_leaves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> state_ff == ST_RUN)
      else $error("report did not end on last");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_mean == '0 && rsp_rms == '0)
      else $error("empty bunch with data");
   a_bunch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_bunch} < 4'(nb)) else $error("bunch out of range");
`endif
endmodule

// ----- verif/per_bunch_beam_moments_top_tb.sv -----
// Self-checking testbench for the per-bunch beam moments block.
module per_bunch_beam_moments_top_tb;
   import pbbm_pkg::*;

   localparam int MAXB = 8;
   localparam int CNT_MAX = 65535;
   localparam int CYCLE_LIMIT = 3000000;

   // One particle as driven on the request channel.
   typedef struct {
      logic signed [23:0] c [6];
      logic lost;
      logic last_p;
   } particle_t;

   // One per-bunch, per-coordinate moment as seen on the response channel.
   typedef struct {
      logic [15:0] turn;
      logic [2:0] bunch;
      logic [2:0] coord;
      logic signed [23:0] mean;
      logic [22:0] rms;
      logic empty_res;
      logic last;
   } moment_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_x = '0, req_px = '0, req_y = '0, req_py = '0;
   logic signed [23:0] req_dp = '0, req_ct = '0;
   logic req_lost = 1'b0, req_last_particle = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [15:0] rsp_turn;
   logic [2:0] rsp_bunch, rsp_coord;
   logic signed [23:0] rsp_mean;
   logic [22:0] rsp_rms;
   logic rsp_empty_res, rsp_last;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   per_bunch_beam_moments_top dut (.*);

   always #5 clock = ~clock;

   // Shadow copy of the block state.
   logic [3:0] shadow_bunch_count;
   int unsigned next_bunch;
   int unsigned live [MAXB];
   logic signed [SUM_W-1:0] sums [MAXB*6];
   logic [SQ_W-1:0] squares [MAXB*6];
   logic [15:0] turn_no;

   moment_t pending_moments [$];
   moment_t first_rsp;
   bit got_first = 1'b0;
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;   // no idling in the final stretch
   bit drain_rsp = 1'b0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int unsigned active_bunches();
      if (shadow_bunch_count == 0) return 1;
      if (shadow_bunch_count > MAXB) return MAXB;
      return shadow_bunch_count;
   endfunction

   function automatic void clear_moments();
      for (int i = 0; i < MAXB; i++) live[i] = 0;
      for (int k = 0; k < MAXB*6; k++) begin
         sums[k] = '0;
         squares[k] = '0;
      end
   endfunction

   // Accumulate one accepted particle and queue the moments it releases.
   function automatic void predict_moments(input particle_t p);
      int unsigned nb, b, k;
      logic signed [63:0] v, mn, cnt;
      logic [63:0] q, msq, r;
      moment_t m;
      nb = active_bunches();
      b = next_bunch;
      if (b >= nb) b = 0;
      if (!p.lost && live[b] < CNT_MAX) begin
         live[b]++;
         for (int c = 0; c < 6; c++) begin
            v = p.c[c];
            sums[b*6+c] = sums[b*6+c] + v;
            squares[b*6+c] = squares[b*6+c] + 64'(v * v);
         end
      end
      next_bunch = (b + 1 >= nb) ? 0 : b + 1;
      if (p.last_p) begin
         for (int i = 0; i < nb; i++) begin
            for (int c = 0; c < 6; c++) begin
               k = i*6 + c;
               m.turn = turn_no;
               m.bunch = 3'(i);
               m.coord = 3'(c);
               m.mean = '0;
               m.rms = '0;
               m.empty_res = 1'b1;
               if (live[i] != 0) begin
                  cnt = live[i];
                  mn = 64'(sums[k]) / cnt;
                  msq = 64'(mn * mn);
                  q = squares[k] / 64'(cnt);
                  r = int_sqrt(q > msq ? q - msq : 64'd0);
                  if (r > 64'h7FFFFF) r = 64'h7FFFFF;
                  m.mean = mn[23:0];
                  m.rms = r[22:0];
                  m.empty_res = 1'b0;
               end
               m.last = (i + 1 == nb && c == 5);
               pending_moments.push_back(m);
            end
         end
         clear_moments();
         next_bunch = 0;
         turn_no++;
      end
   endfunction

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("per_bunch_beam_moments_top test failed");
         $finish;
      end
   end

   // Compare each accepted result with the oldest expected moment.
   always @(posedge clock) begin
      moment_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (!got_first) begin
            first_rsp.turn = rsp_turn;
            first_rsp.bunch = rsp_bunch;
            first_rsp.coord = rsp_coord;
            first_rsp.mean = rsp_mean;
            first_rsp.rms = rsp_rms;
            first_rsp.empty_res = rsp_empty_res;
            first_rsp.last = rsp_last;
            got_first = 1'b1;
         end
         if (pending_moments.size() == 0) begin
            report_mismatch("unexpected result transaction");
         end else begin
            w = pending_moments.pop_front();
            if (rsp_turn !== w.turn || rsp_bunch !== w.bunch || rsp_coord !== w.coord)
               report_mismatch($sformatf("tag t%0d b%0d c%0d, want t%0d b%0d c%0d",
                  rsp_turn, rsp_bunch, rsp_coord, w.turn, w.bunch, w.coord));
            if (rsp_mean !== w.mean)
               report_mismatch($sformatf("mean %0d want %0d (b%0d c%0d)",
                  rsp_mean, w.mean, w.bunch, w.coord));
            if (rsp_rms !== w.rms)
               report_mismatch($sformatf("rms %0d want %0d (b%0d c%0d)",
                  rsp_rms, w.rms, w.bunch, w.coord));
            if (rsp_empty_res !== w.empty_res)
               report_mismatch($sformatf("empty_res %0b want %0b", rsp_empty_res,
                  w.empty_res));
            if (rsp_last !== w.last)
               report_mismatch($sformatf("last %0b want %0b", rsp_last, w.last));
         end
      end
   end

   // Stall the response side in random bursts, never in the final stretch.
   initial begin
      int n;
      @(negedge clock);
      while (!reset || 1) begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   task automatic csr_write(input logic [1:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      shadow_bunch_count = data[3:0];
   endtask

   // Send one particle after an optional idle burst and update the predictor
   // once it is accepted.
   task automatic send_particle(input particle_t p);
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x <= p.c[0];
      req_px <= p.c[1];
      req_y <= p.c[2];
      req_py <= p.c[3];
      req_dp <= p.c[4];
      req_ct <= p.c[5];
      req_lost <= p.lost;
      req_last_particle <= p.last_p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_moments(p);
      @(negedge clock);
   endtask

   // Hold the request side idle until every expected moment has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_moments.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic particle_t make_particle(input logic signed [23:0] v,
                                               input bit lost, input bit lp);
      particle_t p;
      for (int c = 0; c < 6; c++) p.c[c] = v;
      p.lost = lost;
      p.last_p = lp;
      return p;
   endfunction

   function automatic particle_t rand_particle(input bit lp);
      particle_t p;
      for (int c = 0; c < 6; c++) begin
         case ($urandom_range(0, 4))
            0: p.c[c] = 24'sh7FFFFF;
            1: p.c[c] = 24'sh800000;
            2: p.c[c] = 24'($urandom_range(0, 511)) - 24'sd256;
            default: p.c[c] = 24'($urandom);
         endcase
      end
      p.lost = ($urandom_range(0, 7) == 0);
      p.last_p = lp;
      return p;
   endfunction

   // Directed table: coordinate value, lost flag, end-of-turn flag.
   typedef struct {
      logic signed [23:0] v;
      bit lost;
      bit lp;
   } row_t;

   row_t dir_rows [] = '{
      '{24'sd0, 0, 1},          // turn 0: one bunch, single zero particle
      '{24'sd100, 1, 1},        // turn with only a lost particle: empty bunch
      '{24'sh7FFFFF, 0, 0},     // positive extreme
      '{24'sh800000, 0, 1},     // negative extreme, large spread
      '{24'sh800000, 0, 0},
      '{24'sh800000, 0, 1},     // identical extremes: rms zero
      '{24'sd1, 0, 0},
      '{-24'sd1, 0, 0},
      '{24'sd3, 1, 1}           // lost end-of-turn particle: mean of 1 and -1 is zero
   };

   initial begin
      int turns, lp_gap, target;
      row_t r;
      shadow_bunch_count = 4'd1;
      next_bunch = 0;
      turn_no = '0;
      clear_moments();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows with one bunch.
      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         send_particle(make_particle(r.v, r.lost, r.lp));
      end
      wait_drained();
      // Typed-in anchor: after reset the first moment is turn 0, bunch 0, x, all zero.
      if (!got_first || first_rsp.turn !== 16'd0 || first_rsp.bunch !== 3'd0
          || first_rsp.coord !== 3'd0 || first_rsp.mean !== 24'sd0
          || first_rsp.rms !== 23'd0 || first_rsp.empty_res !== 1'b0
          || first_rsp.last !== 1'b0)
         report_mismatch("first moment after reset is not turn 0, bunch 0, all zero");

      // Bunch count extremes: zero, above maximum, maximum, changed mid-turn.
      csr_write(2'(REG_BUNCH_COUNT * 4), 32'd0);
      send_particle(make_particle(24'sd5, 0, 1));
      wait_drained();
      csr_write(2'(REG_BUNCH_COUNT * 4), 32'd15);
      for (int i = 0; i < 9; i++) send_particle(make_particle(24'(i * 7), i == 3, i == 8));
      wait_drained();
      csr_write(2'(REG_BUNCH_COUNT * 4), 32'd8);
      for (int i = 0; i < 6; i++) send_particle(make_particle(24'(i), 0, 0));
      wait_drained();
      csr_write(2'(REG_BUNCH_COUNT * 4), 32'd3);  // particle_bunch now wraps to 0
      send_particle(make_particle(24'sh7FFFFF, 0, 1));
      wait_drained();

      // Random turns over several bunch counts.
      target = 80;
      turns = 0;
      while (target > 0) begin
         csr_write(2'(REG_BUNCH_COUNT * 4), 32'($urandom_range(1, 8)));
         repeat ($urandom_range(1, 3)) begin
            lp_gap = $urandom_range(0, 14);
            for (int i = 0; i <= lp_gap; i++) begin
               send_particle(rand_particle(i == lp_gap));
               target--;
            end
            turns++;
            if (target < 25) quiet = 1'b1;
         end
         wait_drained();
      end
      csr_write(2'(REG_BUNCH_COUNT * 4), 32'd1);

      req_valid <= 1'b0;
      repeat (200) @(negedge clock);
      if (errors == 0 && pending_moments.size() == 0)
         $display("per_bunch_beam_moments_top test passed");
      else
         $display("per_bunch_beam_moments_top test failed");
      $finish;
   end

endmodule

// ----- per_bunch_beam_moments_top.f -----
sv/pbbm_pkg.sv
sv/pbbm_lane.sv
sv/pbbm_stats.sv
sv/per_bunch_beam_moments_top.sv
verif/per_bunch_beam_moments_top_tb.sv
